FILE: rtl/core/rrts_pkg.sv
`timescale 1ns / 1ps

package rrts_pkg;

    // Command codes carried by a request.
    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_SET    = 2'd3
    } t_cmd;

    // Result status codes.
    typedef enum logic [1:0] {
        STS_OK         = 2'd0,
        STS_EMPTY      = 2'd1,
        STS_NOT_MEMBER = 2'd2,
        STS_MEMBER     = 2'd3
    } t_status;

    // Task run states as stored in the state table.
    localparam logic [1:0] ST_READY   = 2'd0;
    localparam logic [1:0] ST_RUNNING = 2'd1;
    localparam logic [1:0] ST_WAITING = 2'd2;

    // Source of the table read address.
    typedef enum logic [1:0] {
        RD_SLOT = 2'd0,
        RD_HEAD = 2'd1,
        RD_CUR  = 2'd2,
        RD_LINK = 2'd3
    } t_rd_sel;

    // Source of the data written into the link table.
    typedef enum logic [1:0] {
        LWD_SLOT = 2'd0,
        LWD_HEAD = 2'd1,
        LWD_TMP  = 2'd2
    } t_lw_data;

    typedef struct packed {
        t_rd_sel  rd_sel;
        logic     step_clr;
        logic     step_inc;
        logic     cap_in;
        logic     save_link;
        logic     link_we;
        logic     link_wa_data;
        t_lw_data link_wd;
        logic     st_we;
        logic     st_wa_data;
        logic     st_wd_new;
        logic     mem_set;
        logic     mem_clr;
        logic     head_set_slot;
        logic     head_set_tmp;
        logic     cur_set_slot;
        logic     cur_set_data;
        logic     rv_set;
        logic     rv_clr;
        logic     res_load;
        t_status  status;
        logic     switched;
    } t_dp_cmd;

    typedef struct packed {
        logic in_range;
        logic member;
        logic ring_valid;
        logic link_eq_head;
        logic link_eq_slot;
        logic head_eq_slot;
        logic addr_eq_cur;
        logic st_ready;
        logic st_running;
        logic step_max;
        logic ns_valid;
    } t_dp_stat;

endpackage

FILE: rtl/core/rrts_cmd_if.sv
`timescale 1ns / 1ps

interface rrts_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [3:0] slot;
    logic [1:0] new_state;

    modport source (output valid, output cmd, output slot, output new_state, input ready);
    modport sink (input valid, input cmd, input slot, input new_state, output ready);
endinterface

FILE: rtl/core/rrts_res_if.sv
`timescale 1ns / 1ps

interface rrts_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       switched;
    logic [3:0] current_slot;
    logic       ring_nonempty;

    modport source (output valid, output status, output switched, output current_slot,
                    output ring_nonempty, input ready);
    modport sink (input valid, input status, input switched, input current_slot,
                  input ring_nonempty, output ready);
endinterface

FILE: rtl/core/rrts_datapath.sv
`timescale 1ns / 1ps

module rrts_datapath #(
    parameter int MAX_TASKS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rrts_pkg::t_dp_cmd     i_cmd,
    input  logic [3:0]            i_slot,
    input  logic [1:0]            i_new_state,
    output rrts_pkg::t_dp_stat    o_stat,
    output rrts_pkg::t_status     o_status,
    output logic                  o_switched,
    output logic [3:0]            o_current_slot,
    output logic                  o_ring_nonempty
);

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    logic [3:0]           r_slot;
    logic [1:0]           r_ns;
    logic [IW-1:0]        r_head;
    logic [IW-1:0]        r_current;
    logic                 r_ring_valid;
    logic [MAX_TASKS-1:0] r_member;
    logic [MAX_TASKS-1:0] r_st_vld;
    logic [CW-1:0]        r_steps;

    logic [IW-1:0]        link_mem [MAX_TASKS];
    logic [1:0]           st_mem [MAX_TASKS];

    logic [IW-1:0]        r_link_q;
    logic [IW-1:0]        r_addr_q;
    logic [1:0]           r_st_q;
    logic                 r_st_v;
    logic [IW-1:0]        r_tmp;

    rrts_pkg::t_status    r_out_status;
    logic                 r_out_switched;
    logic [3:0]           r_out_current;
    logic                 r_out_nonempty;

    logic [IW-1:0]        w_slot_idx;
    logic [IW-1:0]        w_raddr;
    logic [IW-1:0]        w_link_wa;
    logic [IW-1:0]        w_link_wd;
    logic [IW-1:0]        w_st_wa;
    logic [1:0]           w_st_wd;
    logic [1:0]           w_st_rd;

    assign w_slot_idx = IW'(r_slot);

    always_comb begin
        case (i_cmd.rd_sel)
            rrts_pkg::RD_SLOT: w_raddr = w_slot_idx;
            rrts_pkg::RD_HEAD: w_raddr = r_head;
            rrts_pkg::RD_CUR:  w_raddr = r_current;
            rrts_pkg::RD_LINK: w_raddr = r_link_q;
            default:           w_raddr = r_link_q;
        endcase
    end

    always_comb begin
        case (i_cmd.link_wd)
            rrts_pkg::LWD_SLOT: w_link_wd = w_slot_idx;
            rrts_pkg::LWD_HEAD: w_link_wd = r_head;
            rrts_pkg::LWD_TMP:  w_link_wd = r_tmp;
            default:            w_link_wd = r_tmp;
        endcase
    end

    assign w_link_wa = i_cmd.link_wa_data ? r_addr_q : w_slot_idx;
    assign w_st_wa   = i_cmd.st_wa_data ? r_addr_q : w_slot_idx;
    assign w_st_wd   = i_cmd.st_wd_new ? r_ns : rrts_pkg::ST_READY;

    // Link and state tables: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.link_we) begin
            link_mem[w_link_wa] <= w_link_wd;
        end
        if (i_cmd.st_we) begin
            st_mem[w_st_wa] <= w_st_wd;
        end
        r_link_q <= link_mem[w_raddr];
        r_st_q   <= st_mem[w_raddr];
        r_st_v   <= r_st_vld[w_raddr];
        r_addr_q <= w_raddr;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_slot <= i_slot;
            r_ns   <= i_new_state;
        end
        if (i_cmd.save_link) begin
            r_tmp <= r_link_q;
        end
        if (i_cmd.res_load) begin
            r_out_status   <= i_cmd.status;
            r_out_switched <= i_cmd.switched;
            r_out_current  <= 4'(r_current);
            r_out_nonempty <= r_ring_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_current    <= '0;
            r_ring_valid <= 1'b0;
            r_member     <= '0;
            r_st_vld     <= '0;
            r_steps      <= '0;
        end else begin
            if (i_cmd.head_set_slot) begin
                r_head <= w_slot_idx;
            end else if (i_cmd.head_set_tmp) begin
                r_head <= r_tmp;
            end
            if (i_cmd.cur_set_slot) begin
                r_current <= w_slot_idx;
            end else if (i_cmd.cur_set_data) begin
                r_current <= r_addr_q;
            end
            if (i_cmd.rv_set) begin
                r_ring_valid <= 1'b1;
            end else if (i_cmd.rv_clr) begin
                r_ring_valid <= 1'b0;
            end
            if (i_cmd.mem_set) begin
                r_member[w_slot_idx] <= 1'b1;
            end else if (i_cmd.mem_clr) begin
                r_member[w_slot_idx] <= 1'b0;
            end
            if (i_cmd.st_we) begin
                r_st_vld[w_st_wa] <= 1'b1;
            end
            if (i_cmd.step_clr) begin
                r_steps <= '0;
            end else if (i_cmd.step_inc) begin
                r_steps <= r_steps + CW'(1);
            end
        end
    end

    // An entry of the state table that has never been written reads as ready.
    assign w_st_rd = r_st_v ? r_st_q : rrts_pkg::ST_READY;

    always_comb begin
        o_stat.in_range     = (32'(r_slot) < MAX_TASKS);
        o_stat.member       = r_member[w_slot_idx];
        o_stat.ring_valid   = r_ring_valid;
        o_stat.link_eq_head = (r_link_q == r_head);
        o_stat.link_eq_slot = (r_link_q == w_slot_idx);
        o_stat.head_eq_slot = (r_head == w_slot_idx);
        o_stat.addr_eq_cur  = (r_addr_q == r_current);
        o_stat.st_ready     = (w_st_rd == rrts_pkg::ST_READY);
        o_stat.st_running   = (w_st_rd == rrts_pkg::ST_RUNNING);
        o_stat.step_max     = (r_steps == CW'(MAX_TASKS));
        o_stat.ns_valid     = (r_ns <= rrts_pkg::ST_WAITING);
    end

    assign o_status        = r_out_status;
    assign o_switched      = r_out_switched;
    assign o_current_slot  = r_out_current;
    assign o_ring_nonempty = r_out_nonempty;

endmodule

FILE: rtl/core/rrts_controller.sv
`timescale 1ns / 1ps

module rrts_controller (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [1:0]         i_in_cmd,
    input  logic               i_out_ready,
    input  rrts_pkg::t_dp_stat i_stat,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output rrts_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_DECODE    = 9'b000000010,
        S_ADD_WALK  = 9'b000000100,
        S_ADD_TAIL  = 9'b000001000,
        S_REM_SLOT  = 9'b000010000,
        S_REM_WALK  = 9'b000100000,
        S_TICK_CUR  = 9'b001000000,
        S_TICK_WALK = 9'b010000000,
        S_FIN       = 9'b100000000
    } t_state;

    t_state             r_state, n_state;
    rrts_pkg::t_cmd     r_cmd;
    rrts_pkg::t_status  r_status, n_status;
    logic               r_switched, n_switched;
    logic               r_out_valid, n_out_valid;
    logic               w_accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_switched  = r_switched;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.cap_in = 1'b1;
                    n_state      = S_DECODE;
                end
            end

            S_DECODE: begin
                n_switched = 1'b0;
                n_status   = rrts_pkg::STS_OK;
                n_state    = S_FIN;
                case (r_cmd)
                    rrts_pkg::CMD_ADD: begin
                        if (!i_stat.in_range) begin
                            n_status = rrts_pkg::STS_NOT_MEMBER;
                        end else if (i_stat.member) begin
                            n_status = rrts_pkg::STS_MEMBER;
                        end else if (!i_stat.ring_valid) begin
                            // First task: it links to itself and becomes head and current.
                            o_cmd.link_we       = 1'b1;
                            o_cmd.link_wd       = rrts_pkg::LWD_SLOT;
                            o_cmd.head_set_slot = 1'b1;
                            o_cmd.cur_set_slot  = 1'b1;
                            o_cmd.rv_set        = 1'b1;
                            o_cmd.mem_set       = 1'b1;
                            o_cmd.st_we         = 1'b1;
                        end else begin
                            o_cmd.rd_sel   = rrts_pkg::RD_HEAD;
                            o_cmd.step_clr = 1'b1;
                            n_state        = S_ADD_WALK;
                        end
                    end
                    rrts_pkg::CMD_REMOVE: begin
                        if (!i_stat.in_range) begin
                            n_status = rrts_pkg::STS_NOT_MEMBER;
                        end else if (!i_stat.ring_valid) begin
                            n_status = rrts_pkg::STS_EMPTY;
                        end else if (!i_stat.member) begin
                            n_status = rrts_pkg::STS_NOT_MEMBER;
                        end else begin
                            o_cmd.mem_clr = 1'b1;
                            o_cmd.rd_sel  = rrts_pkg::RD_SLOT;
                            n_state       = S_REM_SLOT;
                        end
                    end
                    rrts_pkg::CMD_TICK: begin
                        if (!i_stat.ring_valid) begin
                            n_status = rrts_pkg::STS_EMPTY;
                        end else begin
                            o_cmd.rd_sel = rrts_pkg::RD_CUR;
                            n_state      = S_TICK_CUR;
                        end
                    end
                    default: begin
                        if (!i_stat.in_range) begin
                            n_status = rrts_pkg::STS_NOT_MEMBER;
                        end else if (i_stat.ns_valid) begin
                            o_cmd.st_we     = 1'b1;
                            o_cmd.st_wd_new = 1'b1;
                        end
                    end
                endcase
            end

            S_ADD_WALK: begin
                if (!i_stat.link_eq_head && !i_stat.step_max) begin
                    o_cmd.rd_sel   = rrts_pkg::RD_LINK;
                    o_cmd.step_inc = 1'b1;
                end else begin
                    // Tail found: point it at the new slot.
                    o_cmd.link_we      = 1'b1;
                    o_cmd.link_wa_data = 1'b1;
                    o_cmd.link_wd      = rrts_pkg::LWD_SLOT;
                    n_state            = S_ADD_TAIL;
                end
            end

            S_ADD_TAIL: begin
                o_cmd.link_we = 1'b1;
                o_cmd.link_wd = rrts_pkg::LWD_HEAD;
                o_cmd.mem_set = 1'b1;
                o_cmd.st_we   = 1'b1;
                n_state       = S_FIN;
            end

            S_REM_SLOT: begin
                o_cmd.save_link = 1'b1;
                if (i_stat.head_eq_slot && i_stat.link_eq_slot) begin
                    o_cmd.rv_clr = 1'b1;
                    n_state      = S_FIN;
                end else begin
                    o_cmd.rd_sel   = rrts_pkg::RD_HEAD;
                    o_cmd.step_clr = 1'b1;
                    n_state        = S_REM_WALK;
                end
            end

            S_REM_WALK: begin
                if (!i_stat.link_eq_slot && !i_stat.link_eq_head && !i_stat.step_max) begin
                    o_cmd.rd_sel   = rrts_pkg::RD_LINK;
                    o_cmd.step_inc = 1'b1;
                end else begin
                    if (i_stat.link_eq_slot) begin
                        o_cmd.link_we      = 1'b1;
                        o_cmd.link_wa_data = 1'b1;
                        o_cmd.link_wd      = rrts_pkg::LWD_TMP;
                        o_cmd.head_set_tmp = i_stat.head_eq_slot;
                    end
                    n_state = S_FIN;
                end
            end

            S_TICK_CUR: begin
                // A running current task drops back to ready before the search.
                if (i_stat.st_running) begin
                    o_cmd.st_we      = 1'b1;
                    o_cmd.st_wa_data = 1'b1;
                end
                o_cmd.rd_sel   = rrts_pkg::RD_LINK;
                o_cmd.step_clr = 1'b1;
                n_state        = S_TICK_WALK;
            end

            S_TICK_WALK: begin
                if (!i_stat.addr_eq_cur && !i_stat.st_ready && !i_stat.step_max) begin
                    o_cmd.rd_sel   = rrts_pkg::RD_LINK;
                    o_cmd.step_inc = 1'b1;
                end else begin
                    if (i_stat.st_ready && !i_stat.addr_eq_cur) begin
                        o_cmd.cur_set_data = 1'b1;
                        n_switched         = 1'b1;
                    end
                    n_state = S_FIN;
                end
            end

            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.res_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        o_cmd.status   = r_status;
        o_cmd.switched = r_switched;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_status    <= rrts_pkg::STS_OK;
            r_switched  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_status    <= n_status;
            r_switched  <= n_switched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= rrts_pkg::t_cmd'(i_in_cmd);
        end
    end

endmodule

FILE: rtl/core/round_robin_task_ring_scheduler.sv
`timescale 1ns / 1ps

// Round-robin task ring scheduler over MAX_TASKS task slots.
// Requests arrive on i_cmd (cmd, slot, new_state): add a slot at the ring's
// tail, remove a slot, a scheduler tick, or set a slot's run state. Each
// request yields exactly one result on o_res (status, switched,
// current_slot, ring_nonempty), in request order.
// The block works on one request at a time. A set request, or any request
// rejected by its checks, goes from decode straight to the result stage.
// Add, remove and tick walk the link table one slot per cycle through its
// single registered read port, following at most MAX_TASKS links; removing
// the last task needs no walk. The next request can be taken in the cycle
// after the result is loaded.
// i_cmd.ready is high only while the block waits for a request.
// The result sits in an output register; the next request is taken while
// it waits, and a stalled receiver only holds the following result back.
// Reset (synchronous, active low) empties the ring, marks every slot ready
// and clears all membership; no clearing pass follows, so a request can be
// taken on the first cycle after reset.

module round_robin_task_ring_scheduler #(
    parameter int MAX_TASKS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rrts_cmd_if.sink   i_cmd,
    rrts_res_if.source o_res
);

    rrts_pkg::t_dp_cmd  w_dp_cmd;
    rrts_pkg::t_dp_stat w_dp_stat;
    rrts_pkg::t_status  w_status;
    logic               w_in_ready;
    logic               w_out_valid;

    rrts_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .i_in_cmd    (i_cmd.cmd),
        .i_out_ready (o_res.ready),
        .i_stat      (w_dp_stat),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_dp_cmd)
    );

    rrts_datapath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_dp_cmd),
        .i_slot          (i_cmd.slot),
        .i_new_state     (i_cmd.new_state),
        .o_stat          (w_dp_stat),
        .o_status        (w_status),
        .o_switched      (o_res.switched),
        .o_current_slot  (o_res.current_slot),
        .o_ring_nonempty (o_res.ring_nonempty)
    );

    assign i_cmd.ready  = w_in_ready;
    assign o_res.valid  = w_out_valid;
    assign o_res.status = w_status;

endmodule

FILE: rtl/core/rrts_checker.sv
`timescale 1ns / 1ps

module rrts_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic [1:0] i_res_status,
    input logic       i_res_switched,
    input logic       i_res_nonempty
);

    // No result may be presented in the cycle after reset.
    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid straight after reset");

    // A switch only comes from a successful tick on a populated ring.
    a_switch_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_switched) |->
            (i_res_status == rrts_pkg::STS_OK && i_res_nonempty))
        else $error("switch reported with bad status or empty ring");

    // An empty-ring status must agree with the ring flag.
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_status == rrts_pkg::STS_EMPTY) |-> !i_res_nonempty)
        else $error("empty status while the ring holds tasks");

    // A stalled result holds still.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
            (i_res_valid && $stable(i_res_status) && $stable(i_res_switched)
             && $stable(i_res_nonempty)))
        else $error("stalled result changed");

endmodule

bind round_robin_task_ring_scheduler rrts_checker u_rrts_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_res_status   (o_res.status),
    .i_res_switched (o_res.switched),
    .i_res_nonempty (o_res.ring_nonempty)
);
